### rtl/qtm_pkg.sv
// Shared types and constants for the quaternion TRS to matrix pipeline.
package qtm_pkg;

	localparam int unsigned CompW  = 16;
	localparam int unsigned MoveW  = 32;
	localparam int unsigned ProdW  = 2 * CompW;
	localparam int unsigned RotW   = ProdW + 2;
	localparam int unsigned MulW   = RotW + CompW;
	localparam int unsigned OutW   = 32;
	localparam int unsigned FracRot  = 28;
	localparam int unsigned DropBits = 24;
	localparam int unsigned NumProd  = 9;
	localparam int unsigned NumRot   = 9;
	localparam int unsigned NumAxis  = 3;

	localparam logic signed [RotW-1:0] OneRot  = RotW'(1) << FracRot;
	localparam logic signed [MulW-1:0] HalfDrop = MulW'(1) << (DropBits - 1);

	// Positions of the component products.
	localparam int unsigned PXX = 0;
	localparam int unsigned PYY = 1;
	localparam int unsigned PZZ = 2;
	localparam int unsigned PXY = 3;
	localparam int unsigned PXZ = 4;
	localparam int unsigned PYZ = 5;
	localparam int unsigned PXW = 6;
	localparam int unsigned PYW = 7;
	localparam int unsigned PZW = 8;

	typedef struct packed {
		logic signed [CompW-1:0] quat_x;
		logic signed [CompW-1:0] quat_y;
		logic signed [CompW-1:0] quat_z;
		logic signed [CompW-1:0] quat_w;
		logic signed [CompW-1:0] scale_x;
		logic signed [CompW-1:0] scale_y;
		logic signed [CompW-1:0] scale_z;
		logic signed [MoveW-1:0] move_x;
		logic signed [MoveW-1:0] move_y;
		logic signed [MoveW-1:0] move_z;
	} xform_t;

	typedef struct packed {
		logic signed [OutW-1:0] m00;
		logic signed [OutW-1:0] m01;
		logic signed [OutW-1:0] m02;
		logic signed [OutW-1:0] m10;
		logic signed [OutW-1:0] m11;
		logic signed [OutW-1:0] m12;
		logic signed [OutW-1:0] m20;
		logic signed [OutW-1:0] m21;
		logic signed [OutW-1:0] m22;
		logic signed [OutW-1:0] row3_x;
		logic signed [OutW-1:0] row3_y;
		logic signed [OutW-1:0] row3_z;
	} mat_t;

	typedef struct packed {
		logic signed [MoveW-1:0] x;
		logic signed [MoveW-1:0] y;
		logic signed [MoveW-1:0] z;
	} move_t;

endpackage

### rtl/quaternion_trs_to_matrix.sv
// Top level: quaternion, scale and translation to a row-vector world matrix.
//
// One transform beat enters on xform (xform_valid / xform_stall) and one
// matrix beat leaves on mat (mat_valid / mat_stall) for each of them, in
// order. A beat is taken at a rising edge with valid high and stall low.
//
// The datapath is a four-stage pipeline: component products, rotation
// elements, scale multiply, and rounding into the output register. A beat
// accepted into stage one moves on through stages two and three to stage
// four, which drives mat. One beat per cycle is taken when the output
// side does not stall.
//
// Each stage holds its own valid bit. When mat_stall is high the output
// beat holds still, and earlier stages keep moving until they run into it,
// so empty slots are filled up before xform_stall rises. xform_stall is
// high only when all four stages hold a beat and the output is stalled.
//
// Reset clears all valid bits; the block is ready right after reset.
module quaternion_trs_to_matrix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            xform_valid,
	output logic            xform_stall,
	input  qtm_pkg::xform_t xform,
	output logic            mat_valid,
	input  logic            mat_stall,
	output qtm_pkg::mat_t   mat
);
	import qtm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [ProdW-1:0] prod_s1 [NumProd];
	logic signed [CompW-1:0] sc_s1 [NumAxis];
	logic signed [RotW-1:0]  rot_s2 [NumRot];
	logic signed [CompW-1:0] sc_s2 [NumAxis];
	logic signed [OutW-1:0]  res_s4 [NumRot];
	move_t move_s1, move_s2, move_s3, move_s4;

	// A stage can load when it is empty or the next stage loads too.
	always_comb begin
		rdy4 = !v_s4 || !mat_stall;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
	end

	assign xform_stall = !rdy1;
	assign mat_valid   = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= xform_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			move_s1.x <= xform.move_x;
			move_s1.y <= xform.move_y;
			move_s1.z <= xform.move_z;
		end
		if (rdy2) move_s2 <= move_s1;
		if (rdy3) move_s3 <= move_s2;
		if (rdy4) move_s4 <= move_s3;
	end

	qtm_prod u_prod (
		.clk     (clk),
		.en      (rdy1),
		.xf      (xform),
		.prod_s1 (prod_s1),
		.sc_s1   (sc_s1)
	);

	qtm_rot u_rot (
		.clk     (clk),
		.en      (rdy2),
		.prod_s1 (prod_s1),
		.sc_s1   (sc_s1),
		.rot_s2  (rot_s2),
		.sc_s2   (sc_s2)
	);

	for (genvar i = 0; i < NumRot; i++) begin : g_lane
		qtm_lane u_lane (
			.clk    (clk),
			.en_s3  (rdy3),
			.en_s4  (rdy4),
			.rot_s2 (rot_s2[i]),
			.sc_s2  (sc_s2[i / NumAxis]),
			.res_s4 (res_s4[i])
		);
	end

	always_comb begin
		mat.m00    = res_s4[0];
		mat.m01    = res_s4[1];
		mat.m02    = res_s4[2];
		mat.m10    = res_s4[3];
		mat.m11    = res_s4[4];
		mat.m12    = res_s4[5];
		mat.m20    = res_s4[6];
		mat.m21    = res_s4[7];
		mat.m22    = res_s4[8];
		mat.row3_x = move_s4.x;
		mat.row3_y = move_s4.y;
		mat.row3_z = move_s4.z;
	end

	a_empty_first_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !xform_stall)
		else $error("input stalled while the first stage is empty");

	a_free_output_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s4 || !mat_stall) |-> !xform_stall)
		else $error("input stalled while the output is free");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && mat_stall) |-> (xform_stall == (v_s1 && v_s2 && v_s3)))
		else $error("input stall does not match pipeline occupancy");

	a_beat_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !mat_stall) |=> v_s4)
		else $error("a beat in stage three was lost on a free output");

endmodule

### rtl/qtm_prod.sv
// Stage one: the nine pairwise quaternion component products.
module qtm_prod (
	input  logic                            clk,
	input  logic                            en,
	input  qtm_pkg::xform_t                 xf,
	output logic signed [qtm_pkg::ProdW-1:0] prod_s1 [qtm_pkg::NumProd],
	output logic signed [qtm_pkg::CompW-1:0] sc_s1 [qtm_pkg::NumAxis]
);
	import qtm_pkg::*;

	logic signed [ProdW-1:0] prod [NumProd];

	always_comb begin
		prod[PXX] = xf.quat_x * xf.quat_x;
		prod[PYY] = xf.quat_y * xf.quat_y;
		prod[PZZ] = xf.quat_z * xf.quat_z;
		prod[PXY] = xf.quat_x * xf.quat_y;
		prod[PXZ] = xf.quat_x * xf.quat_z;
		prod[PYZ] = xf.quat_y * xf.quat_z;
		prod[PXW] = xf.quat_x * xf.quat_w;
		prod[PYW] = xf.quat_y * xf.quat_w;
		prod[PZW] = xf.quat_z * xf.quat_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= prod;
			sc_s1[0] <= xf.scale_x;
			sc_s1[1] <= xf.scale_y;
			sc_s1[2] <= xf.scale_z;
		end
	end

endmodule

### rtl/qtm_rot.sv
// Stage two: rotation matrix elements in Q.28 from the component products.
module qtm_rot (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [qtm_pkg::ProdW-1:0] prod_s1 [qtm_pkg::NumProd],
	input  logic signed [qtm_pkg::CompW-1:0] sc_s1 [qtm_pkg::NumAxis],
	output logic signed [qtm_pkg::RotW-1:0]  rot_s2 [qtm_pkg::NumRot],
	output logic signed [qtm_pkg::CompW-1:0] sc_s2 [qtm_pkg::NumAxis]
);
	import qtm_pkg::*;

	logic signed [RotW-1:0] p [NumProd];
	logic signed [RotW-1:0] rot [NumRot];

	// Sign-extend the products first so that every sum is formed exactly.
	always_comb begin
		for (int i = 0; i < NumProd; i++) begin
			p[i] = {{(RotW - ProdW){prod_s1[i][ProdW-1]}}, prod_s1[i]};
		end
		rot[0] = OneRot - ((p[PYY] + p[PZZ]) <<< 1);
		rot[1] = (p[PXY] + p[PZW]) <<< 1;
		rot[2] = (p[PXZ] - p[PYW]) <<< 1;
		rot[3] = (p[PXY] - p[PZW]) <<< 1;
		rot[4] = OneRot - ((p[PXX] + p[PZZ]) <<< 1);
		rot[5] = (p[PYZ] + p[PXW]) <<< 1;
		rot[6] = (p[PXZ] + p[PYW]) <<< 1;
		rot[7] = (p[PYZ] - p[PXW]) <<< 1;
		rot[8] = OneRot - ((p[PXX] + p[PYY]) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s2 <= rot;
			sc_s2  <= sc_s1;
		end
	end

endmodule

### rtl/qtm_lane.sv
// Stages three and four for one matrix element: scale multiply, then rounding.
module qtm_lane (
	input  logic                            clk,
	input  logic                            en_s3,
	input  logic                            en_s4,
	input  logic signed [qtm_pkg::RotW-1:0]  rot_s2,
	input  logic signed [qtm_pkg::CompW-1:0] sc_s2,
	output logic signed [qtm_pkg::OutW-1:0]  res_s4
);
	import qtm_pkg::*;

	logic signed [MulW-1:0] mul_s3;
	logic signed [MulW-1:0] biased;
	logic signed [OutW-1:0] res;

	// Round to nearest with ties upward, then drop to Q16.16. The shifted
	// value is at most 26 bits wide, so the signed 32-bit clamp never acts
	// and sign extension alone gives the saturated result.
	always_comb begin
		biased = mul_s3 + HalfDrop;
		res    = {{(OutW - (MulW - DropBits)){biased[MulW-1]}}, biased[MulW-1:DropBits]};
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mul_s3 <= rot_s2 * sc_s2;
		end
		if (en_s4) begin
			res_s4 <= res;
		end
	end

endmodule
